// ----- design/spbm_pkg.sv -----
// ----------------------------------------------------------------------------
// spbm_pkg
// Shared constants, opcodes, status codes and types of the SPI save memory.
// ----------------------------------------------------------------------------
package spbm_pkg;

    localparam int STORE_BYTES = 65536;
    localparam int STORE_AW    = $clog2(STORE_BYTES);

    localparam logic [32:0] STORE_LIM = 33'(STORE_BYTES);
    localparam logic [32:0] HI_OFFSET = 33'h100;

    localparam logic [7:0] OP_NONE = 8'h00;
    localparam logic [7:0] OP_WRLO = 8'h02;
    localparam logic [7:0] OP_RDLO = 8'h03;
    localparam logic [7:0] OP_WRDI = 8'h04;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_WRHI = 8'h0A;
    localparam logic [7:0] OP_RDHI = 8'h0B;

    localparam logic [2:0] CLS_EE1   = 3'd1;
    localparam logic [2:0] CLS_EE2   = 3'd2;
    localparam logic [2:0] CLS_EE3   = 3'd3;
    localparam logic [2:0] CLS_FLASH = 3'd4;

    localparam logic CFG_CLASS = 1'b0;
    localparam logic CFG_BYTES = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOWE    = 3'd1,
        ST_RANGE   = 3'd2,
        ST_CLASS   = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        LAT_KEEP = 2'd0,
        LAT_SET  = 2'd1,
        LAT_LOAD = 2'd2
    } t_lat_op;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } t_mem_req;

    typedef struct packed {
        t_status    status;
        t_lat_op    lat_op;
        logic [7:0] lat_val;
    } t_cmd_res;

endpackage

// ----- design/spi_backup_memory_device.sv -----
// ----------------------------------------------------------------------------
// spi_backup_memory_device
// SPI save memory, one link event per transfer, one result per event.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                         Contents
// s         in         i_s_tvalid/o_s_tready           tuser: cmd, tdata: data_byte
// m         out        o_m_tvalid/i_m_tready           tdata: read_byte, status
// cfg       in         i_cfg_valid/o_cfg_ready         index 0 class, 1 memory size
//
// One transfer per cycle while the output is not stalled; a result passes
// the input register, the decode register with RAM access, and the result register.
// RAM read data is registered alongside the decode result and folds into the latch.
// Synchronous active-low reset clears control state; RAM is not cleared.
// A stalled output freezes the whole pipe; the input register still fills while empty.
// ----------------------------------------------------------------------------
module spi_backup_memory_device (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] read_byte, [10:8] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import spbm_pkg::*;

    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_data;
    logic        r_b_valid;
    t_cmd_res    r_b;
    logic        r_out_valid;
    t_status     r_out_status;
    logic [7:0]  r_latch;
    logic [2:0]  r_class;
    logic [16:0] r_bytes;

    logic        w_adv;
    logic        w_fire;
    t_mem_req    w_req;
    t_cmd_res    w_res;
    logic [7:0]  w_rdata;

    assign w_adv       = !r_out_valid || i_m_tready;
    assign w_fire      = r_in_valid && w_adv;
    assign o_s_tready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    spbm_cmd u_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_cmd   (r_in_cmd),
        .i_data  (r_in_data),
        .i_class (r_class),
        .i_bytes (r_bytes),
        .o_req   (w_req),
        .o_res   (w_res)
    );

    spbm_ram #(
        .DEPTH (STORE_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_req.we),
        .i_re    (w_req.re),
        .i_addr  (w_req.addr),
        .i_wdata (w_req.wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= 3'd0;
            r_bytes <= 17'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CLASS: r_class <= i_cfg_data[2:0];
                CFG_BYTES: r_bytes <= i_cfg_data;
                default:   r_bytes <= r_bytes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd  <= i_s_tuser;
            r_in_data <= i_s_tdata;
        end
        if (w_fire) begin
            r_b <= w_res;
        end
        if (w_adv && r_b_valid) begin
            r_out_status <= r_b.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_latch     <= 8'd0;
        end else if (w_adv) begin
            r_b_valid   <= r_in_valid;
            r_out_valid <= r_b_valid;
            if (r_b_valid) begin
                case (r_b.lat_op)
                    LAT_SET:  r_latch <= r_b.lat_val;
                    LAT_LOAD: r_latch <= w_rdata;
                    default:  r_latch <= r_latch;
                endcase
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_status, r_latch};

`ifndef ASSERT_OFF
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req.we && w_req.re))
        else $error("RAM read and write issued together");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.re |=> (r_b_valid && (r_b.lat_op == LAT_LOAD)))
        else $error("RAM read not followed by a latch load");

    a_req_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.we || w_req.re) |-> w_fire)
        else $error("RAM access without a decoded transfer");

    a_stall_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("input register dropped during stall");

    a_not_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid))
        else $error("input stalled while pipe not full");
`endif

endmodule

// ----- design/spbm_ram.sv -----
// ----------------------------------------------------------------------------
// spbm_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module spbm_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/spbm_cmd.sv -----
// ----------------------------------------------------------------------------
// spbm_cmd
// Command decoder: opcode, write enable and address state, memory requests.
// ----------------------------------------------------------------------------
module spbm_cmd (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_cmd,
    input  logic [7:0]         i_data,
    input  logic [2:0]         i_class,
    input  logic [16:0]        i_bytes,
    output spbm_pkg::t_mem_req o_req,
    output spbm_pkg::t_cmd_res o_res
);
    import spbm_pkg::*;

    logic [7:0]  r_opcode, n_opcode;
    logic        r_we, n_we;
    logic [1:0]  r_seen, n_seen;
    logic [31:0] r_addr, n_addr;

    logic [1:0]  w_len;
    logic        w_is_read;
    logic        w_hi;
    logic        w_need_addr;
    logic [32:0] w_sum;
    logic [32:0] w_bytes;
    logic [32:0] w_limit;
    logic        w_in_range;
    logic [31:0] w_taken;

    always_comb begin
        case (i_class)
            CLS_EE1:   w_len = 2'd1;
            CLS_EE2:   w_len = 2'd2;
            CLS_EE3:   w_len = 2'd3;
            CLS_FLASH: w_len = 2'd3;
            default:   w_len = 2'd0;
        endcase
    end

    assign w_is_read   = (r_opcode == OP_RDLO) || (r_opcode == OP_RDHI);
    assign w_hi        = (r_opcode == OP_RDHI) || (r_opcode == OP_WRHI);
    assign w_need_addr = r_seen < w_len;
    assign w_sum       = {1'b0, r_addr} + ((w_hi && (i_class == CLS_EE1)) ? HI_OFFSET : 33'd0);
    assign w_bytes     = {16'd0, i_bytes};
    assign w_limit     = (w_bytes < STORE_LIM) ? w_bytes : STORE_LIM;
    assign w_in_range  = w_sum < w_limit;
    assign w_taken     = (w_len == 2'd1) ? {24'd0, i_data} : {r_addr[23:0], i_data};

    always_comb begin
        n_opcode = r_opcode;
        n_we     = r_we;
        n_seen   = r_seen;
        n_addr   = r_addr;
        o_res    = '{status: ST_OK, lat_op: LAT_KEEP, lat_val: 8'd0};
        o_req    = '{we: 1'b0, re: 1'b0, addr: w_sum[STORE_AW-1:0], wdata: i_data};
        if (i_fire) begin
            if (i_cmd) begin
                n_opcode = OP_NONE;
                n_seen   = 2'd0;
                n_addr   = 32'd0;
            end else begin
                case (r_opcode)
                    OP_NONE: begin
                        n_opcode = i_data;
                        if ((i_data == OP_RDLO) || (i_data == OP_RDHI) ||
                            (i_data == OP_WRLO) || (i_data == OP_WRHI)) begin
                            n_seen = 2'd0;
                        end else if (i_data == OP_WREN) begin
                            n_we = 1'b1;
                        end else if (i_data == OP_WRDI) begin
                            n_we = 1'b0;
                        end else if (i_data == OP_RDSR) begin
                            o_res.lat_op  = LAT_SET;
                            o_res.lat_val = {6'd0, r_we, 1'b0};
                        end
                    end
                    OP_RDSR: begin
                        o_res.lat_op  = LAT_SET;
                        o_res.lat_val = {6'd0, r_we, 1'b0};
                    end
                    OP_WREN, OP_WRDI: begin
                    end
                    OP_RDLO, OP_RDHI, OP_WRLO, OP_WRHI: begin
                        if (!w_is_read && !r_we) begin
                            o_res.status = ST_NOWE;
                        end else if (w_len == 2'd0) begin
                            o_res.lat_op = LAT_SET;
                        end else if (w_is_read) begin
                            if (w_hi && (i_class != CLS_EE1)) begin
                                o_res.lat_op = LAT_SET;
                                o_res.status = ST_CLASS;
                            end else if (w_need_addr) begin
                                n_addr = w_taken;
                                n_seen = r_seen + 2'd1;
                            end else begin
                                n_addr = r_addr + 32'd1;
                                if (w_in_range) begin
                                    o_req.re     = 1'b1;
                                    o_res.lat_op = LAT_LOAD;
                                end else begin
                                    o_res.lat_op = LAT_SET;
                                end
                            end
                        end else begin
                            if (w_hi && ((i_class == CLS_EE2) || (i_class == CLS_EE3))) begin
                                o_res.status = ST_CLASS;
                            end else if (!w_hi && (i_class == CLS_FLASH)) begin
                                o_res.status = ST_CLASS;
                            end else if (w_need_addr) begin
                                n_addr = w_taken;
                                n_seen = r_seen + 2'd1;
                            end else begin
                                n_addr = r_addr + 32'd1;
                                if (w_in_range) begin
                                    o_req.we = 1'b1;
                                end else begin
                                    o_res.status = ST_RANGE;
                                end
                            end
                        end
                    end
                    default: begin
                        o_res.status = ST_UNKNOWN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode <= OP_NONE;
            r_we     <= 1'b0;
            r_seen   <= 2'd0;
            r_addr   <= 32'd0;
        end else begin
            r_opcode <= n_opcode;
            r_we     <= n_we;
            r_seen   <= n_seen;
            r_addr   <= n_addr;
        end
    end

endmodule

// ----- bench/spi_backup_memory_device_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_backup_memory_device_test
// Streams link events (bytes and deselects) into the save memory under
// several class and size settings. A local model of the opcode decoder and
// save store predicts the latch and status of every reply. Random idling on
// both sides; one long output hold-off; drains between settings.
// ----------------------------------------------------------------------------
module spi_backup_memory_device_test;
    import spbm_pkg::*;

    localparam logic [2:0] CLS_NONE        = 3'd0;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 110;
    localparam int         HOLD_CYCLES     = 150;
    localparam int         QUIET_LIMIT     = 5000;

    typedef enum logic [2:0] {
        EFF_KEEP,
        EFF_FETCH,
        EFF_CLEAR,
        EFF_ENABLE,
        EFF_STORE
    } t_effect;

    typedef struct {
        logic [2:0]  cls;
        logic [16:0] size;
        logic [7:0]  opcode;
        logic        wen;
        logic [1:0]  seen;
        logic [31:0] addr;
    } t_link;

    typedef struct {
        logic       desel;
        logic [7:0] data;
    } t_event;

    typedef struct {
        logic [7:0] latch;
        t_status    status;
    } t_reply;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'h00;
    logic        i_s_tuser   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_CLASS;
    logic [16:0] i_cfg_data  = 17'd0;

    spi_backup_memory_device dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model side
    t_link      model_link = '{default: '0};
    logic [7:0] model_latch = 8'h00;
    logic [7:0] mirror_mem [0:STORE_BYTES-1];
    t_reply     due_replies [$];

    // stimulus side
    t_link       gen_link = '{default: '0};
    bit          gen_written [0:STORE_BYTES-1];
    int unsigned landed [$];
    t_event      pending_events [$];
    int unsigned events_queued = 0;

    int unsigned events_sent  = 0;
    int unsigned replies_seen = 0;
    int unsigned fetches      = 0;
    int unsigned stores       = 0;
    int unsigned errors       = 0;
    int unsigned status_hits [5] = '{default: 0};

    t_event      next_ev;
    int unsigned src_gap   = 0;
    logic        src_calm  = 1'b0;
    int unsigned snk_stall = 0;
    int unsigned snk_gap   = 0;
    logic        snk_calm  = 1'b0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned quiet     = 0;

    function automatic int unsigned addr_len(logic [2:0] cls);
        case (cls)
            CLS_EE1:            return 1;
            CLS_EE2:            return 2;
            CLS_EE3, CLS_FLASH: return 3;
            default:            return 0;
        endcase
    endfunction

    function automatic logic known_opcode(logic [7:0] op);
        return op == OP_NONE || op == OP_WRLO || op == OP_RDLO || op == OP_WRDI ||
               op == OP_RDSR || op == OP_WREN || op == OP_WRHI || op == OP_RDHI;
    endfunction

    // One link event against the control state; the store effect is left
    // to the caller.
    function automatic void step_link(inout t_link s, input logic desel,
                                      input logic [7:0] v, output t_effect eff,
                                      output logic [15:0] loc, output t_status st);
        int unsigned alen;
        logic        is_rd;
        logic        hi;
        logic [32:0] a;
        logic [32:0] lim;
        eff   = EFF_KEEP;
        loc   = '0;
        st    = ST_OK;
        alen  = addr_len(s.cls);
        lim   = ({16'b0, s.size} > STORE_LIM) ? STORE_LIM : {16'b0, s.size};
        is_rd = (s.opcode == OP_RDLO || s.opcode == OP_RDHI);
        hi    = (s.opcode == OP_RDHI || s.opcode == OP_WRHI);
        if (desel) begin
            s.opcode = OP_NONE;
            s.addr   = '0;
            s.seen   = '0;
        end else begin
            case (s.opcode)
                OP_NONE: begin
                    s.opcode = v;
                    if (v == OP_RDLO || v == OP_RDHI || v == OP_WRLO || v == OP_WRHI)
                        s.seen = '0;
                    else if (v == OP_WREN)
                        s.wen = 1'b1;
                    else if (v == OP_WRDI)
                        s.wen = 1'b0;
                    else if (v == OP_RDSR)
                        eff = EFF_ENABLE;
                end
                OP_RDSR: eff = EFF_ENABLE;
                OP_WREN, OP_WRDI: begin
                end
                OP_RDLO, OP_RDHI, OP_WRLO, OP_WRHI: begin
                    if (!is_rd && !s.wen) begin
                        st = ST_NOWE;
                    end else if (alen == 0) begin
                        eff = EFF_CLEAR;
                    end else if (is_rd && hi && s.cls != CLS_EE1) begin
                        eff = EFF_CLEAR;
                        st  = ST_CLASS;
                    end else if (!is_rd && hi && (s.cls == CLS_EE2 || s.cls == CLS_EE3)) begin
                        st = ST_CLASS;
                    end else if (!is_rd && !hi && s.cls == CLS_FLASH) begin
                        st = ST_CLASS;
                    end else if (s.seen < alen) begin
                        s.addr = (alen == 1) ? {24'b0, v} : {s.addr[23:0], v};
                        s.seen = s.seen + 2'd1;
                    end else begin
                        a = {1'b0, s.addr} + ((hi && s.cls == CLS_EE1) ? HI_OFFSET : 33'd0);
                        if (a < lim) begin
                            eff = is_rd ? EFF_FETCH : EFF_STORE;
                            loc = a[15:0];
                        end else if (is_rd) begin
                            eff = EFF_CLEAR;
                        end else begin
                            st = ST_RANGE;
                        end
                        s.addr = s.addr + 32'd1;
                    end
                end
                default: st = ST_UNKNOWN;
            endcase
        end
    endfunction

    function automatic void predict_event(logic desel, logic [7:0] v);
        t_effect     eff;
        logic [15:0] loc;
        t_status     st;
        t_reply      r;
        step_link(model_link, desel, v, eff, loc, st);
        case (eff)
            EFF_FETCH: begin
                model_latch = mirror_mem[loc];
                fetches++;
            end
            EFF_CLEAR:  model_latch = 8'h00;
            EFF_ENABLE: model_latch = {6'b0, model_link.wen, 1'b0};
            EFF_STORE: begin
                mirror_mem[loc] = v;
                stores++;
            end
            default: ;
        endcase
        r.latch  = model_latch;
        r.status = st;
        due_replies.push_back(r);
    endfunction

    function automatic int unsigned pick_gap(logic calm);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned gen_limit();
        return (gen_link.size > 17'(STORE_BYTES)) ? STORE_BYTES : int'(gen_link.size);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_reply(logic [15:0] word);
        t_reply want;
        if (due_replies.size() == 0) begin
            report_mismatch($sformatf("reply %h with nothing expected", word));
        end else begin
            want = due_replies.pop_front();
            replies_seen++;
            status_hits[int'(want.status)]++;
            if (word[7:0] !== want.latch)
                report_mismatch($sformatf("reply %0d read_byte %h, expected %h",
                                          replies_seen, word[7:0], want.latch));
            if (word[10:8] !== 3'(want.status))
                report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                          replies_seen, word[10:8], want.status));
        end
    endtask

    // Queues one event; a read of a never-written entry becomes a deselect.
    task automatic offer(input logic desel, input logic [7:0] v);
        t_link       trial;
        t_effect     eff;
        logic [15:0] loc;
        t_status     st;
        t_event      ev;
        trial = gen_link;
        step_link(trial, desel, v, eff, loc, st);
        if (eff == EFF_FETCH && !gen_written[loc]) begin
            desel = 1'b1;
            trial = gen_link;
            step_link(trial, desel, v, eff, loc, st);
        end
        if (eff == EFF_STORE && !gen_written[loc]) begin
            gen_written[loc] = 1'b1;
            landed.push_back(loc);
        end
        gen_link = trial;
        ev.desel = desel;
        ev.data  = v;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic deselect_link();
        offer(1'b1, 8'($urandom));
    endtask

    task automatic send_addr(int unsigned a);
        int unsigned alen;
        alen = addr_len(gen_link.cls);
        if (alen == 0) offer(1'b0, 8'(a));
        for (int i = int'(alen) - 1; i >= 0; i--) offer(1'b0, 8'(a >> (8 * i)));
    endtask

    task automatic random_transaction();
        int unsigned pick;
        int unsigned lim;
        int unsigned reach;
        int unsigned target;
        int unsigned n;
        logic [7:0]  op;
        logic        ee1;
        pick  = $urandom_range(99);
        lim   = gen_limit();
        ee1   = (gen_link.cls == CLS_EE1);
        reach = (ee1 && lim > 512) ? 512 : lim;
        if (pick < 35) begin
            if (!gen_link.wen && $urandom_range(9) < 8) begin
                offer(1'b0, OP_WREN);
                deselect_link();
            end
            if (reach == 0 || $urandom_range(9) == 0)
                target = reach + $urandom_range(0, 64);
            else if ($urandom_range(3) == 0)
                target = reach - 1 - $urandom_range(0, (reach > 4) ? 3 : reach - 1);
            else
                target = $urandom_range(0, reach - 1);
            op = (gen_link.cls == CLS_FLASH || (ee1 && target >= 256)) ? OP_WRHI : OP_WRLO;
            if (ee1 && target >= 256) target -= 256;
            if ($urandom_range(9) == 0) op = (op == OP_WRHI) ? OP_WRLO : OP_WRHI;
            offer(1'b0, op);
            send_addr(target);
            n = $urandom_range(1, 8);
            repeat (n) offer(1'b0, 8'($urandom));
            deselect_link();
        end else if (pick < 70) begin
            op = OP_RDLO;
            if (landed.size() != 0 && $urandom_range(4) != 0)
                target = landed[$urandom_range(0, landed.size() - 1)];
            else
                target = reach + $urandom_range(0, 300);
            if (ee1 && target >= 256) begin
                op = OP_RDHI;
                target -= 256;
            end
            if ($urandom_range(19) == 0) op = OP_RDHI;
            offer(1'b0, op);
            send_addr(target);
            n = $urandom_range(1, 8);
            repeat (n) offer(1'b0, 8'($urandom));
            deselect_link();
        end else if (pick < 80) begin
            n = $urandom_range(2);
            op = (n == 0) ? OP_RDSR : (n == 1) ? OP_WREN : OP_WRDI;
            offer(1'b0, op);
            n = $urandom_range(0, 3);
            repeat (n) offer(1'b0, 8'($urandom));
            deselect_link();
        end else if (pick < 90) begin
            if ($urandom_range(3) == 0) offer(1'b0, OP_NONE);
            do op = 8'($urandom); while (known_opcode(op));
            offer(1'b0, op);
            n = $urandom_range(0, 4);
            repeat (n) offer(1'b0, 8'($urandom));
            deselect_link();
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) offer($urandom_range(3) == 0, 8'($urandom));
        end
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CLASS) begin
            model_link.cls = val[2:0];
            gen_link.cls   = val[2:0];
        end else begin
            model_link.size = val;
            gen_link.size   = val;
        end
    endtask

    task automatic configure(logic [2:0] cls, logic [16:0] size);
        write_reg(CFG_CLASS, {14'b0, cls});
        write_reg(CFG_BYTES, size);
    endtask

    task automatic wait_quiet();
        while (pending_events.size() != 0 || i_s_tvalid || due_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // input side: driver and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_event(i_s_tuser, i_s_tdata);
                events_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap    <= src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    next_ev = pending_events.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= next_ev.desel;
                    i_s_tdata  <= next_ev.data;
                    if ($urandom_range(63) == 0) src_calm <= !src_calm;
                    src_gap <= pick_gap(src_calm);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: checker and back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) check_reply(o_m_tdata);
            if (hold_left != 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else if (!hold_done && replies_seen >= 200 && pending_events.size() > 30) begin
                hold_done  <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else if (snk_stall != 0) begin
                snk_stall  <= snk_stall - 1;
                i_m_tready <= 1'b0;
            end else if (o_m_tvalid && i_m_tready) begin
                if ($urandom_range(63) == 0) snk_calm <= !snk_calm;
                snk_gap = pick_gap(snk_calm);
                if (snk_gap != 0) snk_stall <= snk_gap - 1;
                i_m_tready <= (snk_gap == 0);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", quiet);
            $display("spi_backup_memory_device verification failed");
            $finish;
        end
    end

    logic [2:0]  phase_cls  [PHASES] = '{CLS_EE1, CLS_EE2, CLS_EE3, CLS_FLASH,
                                         CLS_NONE, CLS_EE2, CLS_EE1, CLS_FLASH};
    logic [16:0] phase_size [PHASES] = '{17'd512, 17'd65536, 17'd1000, 17'd65536,
                                         17'd65536, 17'd0, 17'd300, 17'd200};

    initial begin
        int unsigned goal;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(CLS_EE1, 17'd512);
        offer(1'b0, OP_WREN);
        deselect_link();
        offer(1'b0, OP_RDSR);
        offer(1'b0, 8'hFF);
        deselect_link();
        offer(1'b0, OP_WRLO);
        offer(1'b0, 8'h00);
        offer(1'b0, 8'hFF);
        offer(1'b0, 8'h00);
        deselect_link();
        // upper half; second data byte lands past the end
        offer(1'b0, OP_WRHI);
        offer(1'b0, 8'hFF);
        offer(1'b0, 8'hA5);
        offer(1'b0, 8'h5A);
        deselect_link();
        offer(1'b0, OP_RDLO);
        offer(1'b0, 8'h00);
        offer(1'b0, 8'h00);
        offer(1'b0, 8'h00);
        deselect_link();
        offer(1'b0, OP_RDHI);
        offer(1'b0, 8'hFF);
        offer(1'b0, 8'h00);
        offer(1'b0, 8'h00);
        deselect_link();
        offer(1'b0, OP_NONE);
        offer(1'b0, 8'h77);
        offer(1'b0, 8'h11);
        deselect_link();
        offer(1'b0, OP_WRDI);
        deselect_link();
        offer(1'b0, OP_RDSR);
        deselect_link();
        offer(1'b0, OP_WRLO);
        offer(1'b0, 8'h01);
        offer(1'b0, 8'h3C);
        deselect_link();
        wait_quiet();

        for (int ph = 0; ph < PHASES; ph++) begin
            configure(phase_cls[ph], phase_size[ph]);
            goal = events_queued + ITEMS_PER_PHASE;
            while (events_queued < goal) random_transaction();
            deselect_link();
            wait_quiet();
        end

        repeat (10) @(posedge i_clk);
        $display("checked %0d replies to %0d link events over nine class/size settings",
                 replies_seen, events_sent);
        $display("store reads %0d, stores %0d; ok/no-enable/range/class/unknown %0d/%0d/%0d/%0d/%0d",
                 fetches, stores, status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3], status_hits[4]);
        if (errors == 0)
            $display("spi_backup_memory_device verification clean");
        else
            $display("spi_backup_memory_device verification failed");
        $finish;
    end

endmodule
